// ===== hdl/rpac_pkg.sv =====
// Shared constants and the arctangent table for the rotate-about-center block.
// No dependencies; every other file imports this package.
package rpac_pkg;

  // Default configuration of the top level
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int FRAC_BITS_DEF     = 8;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // CORDIC datapath: x/y in Q2.30, z in units of 2^-32 turn
  localparam int XW         = 32;
  localparam int ZW         = 32;
  localparam int Q_SHIFT    = 30;
  localparam int ATAN_DEPTH = 24;

  localparam logic signed [XW-1:0] GAIN_Q30     = 32'sd652032874;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sd1073741824;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41721;
      15: v = 32'sd20860;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2607;
      19: v = 32'sd1303;
      20: v = 32'sd651;
      21: v = 32'sd325;
      22: v = 32'sd162;
      23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/rpac_cordic_cell.sv =====
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
// Carries the word's offsets and center along. Depends on rpac_pkg.
module rpac_cordic_cell import rpac_pkg::*; #(
  parameter int IDX = 0,
  parameter int DW  = 25,
  parameter int CW  = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic signed [DW-1:0] dx_i,
  input  logic signed [DW-1:0] dy_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic signed [DW-1:0] dx_o,
  output logic signed [DW-1:0] dy_o,
  output logic signed [CW-1:0] cx_o,
  output logic signed [CW-1:0] cy_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_val(IDX);

  logic                 valid_q;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [CW-1:0] cx_q, cy_q;

  // micro-rotation toward z = 0
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
    dx_q <= dx_i;
    dy_q <= dy_i;
    cx_q <= cx_i;
    cy_q <= cy_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;

endmodule

// ===== hdl/rpac_combine.sv =====
// Back end: offset times cos/sin, rounding, center add and saturation.
// Three register stages. Depends on rpac_pkg.
module rpac_combine import rpac_pkg::*; #(
  parameter int DW = 25,
  parameter int CW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] cos_i,
  input  logic signed [XW-1:0] sin_i,
  input  logic signed [DW-1:0] dx_i,
  input  logic signed [DW-1:0] dy_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] rx_o,
  output logic signed [CW-1:0] ry_o,
  output logic                 clip_o
);

  localparam int PW = DW + XW;          // product width
  localparam int SW = PW + 1;           // dot product width
  localparam int RW = SW - Q_SHIFT;     // rounded offset width
  localparam int TW = RW + 1;           // offset plus center

  localparam logic signed [SW-1:0] RND = SW'(1) <<< (Q_SHIFT - 1);
  localparam logic signed [TW-1:0] HI  = TW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [TW-1:0] LO  = -HI - TW'(1);

  // stage 1: products
  logic                 v1_q;
  logic signed [PW-1:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [CW-1:0] cx1_q, cy1_q;

  // stage 2: rounded rotated offsets
  logic                 v2_q;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [RW-1:0] ox_q, oy_q;
  logic signed [CW-1:0] cx2_q, cy2_q;

  // stage 3: center add and clamp
  logic                 v3_q;
  logic signed [TW-1:0] tx, ty;
  logic signed [CW-1:0] rx_d, ry_d, rx_q, ry_q;
  logic                 clx, cly, clip_q;

  always_comb begin
    sum_x = SW'(p_xc_q) - SW'(p_ys_q) + RND;
    sum_y = SW'(p_xs_q) + SW'(p_yc_q) + RND;
  end

  always_comb begin
    tx  = TW'(ox_q) + TW'(cx2_q);
    ty  = TW'(oy_q) + TW'(cy2_q);
    clx = (tx > HI) || (tx < LO);
    cly = (ty > HI) || (ty < LO);
    if (tx > HI)      rx_d = HI[CW-1:0];
    else if (tx < LO) rx_d = LO[CW-1:0];
    else              rx_d = tx[CW-1:0];
    if (ty > HI)      ry_d = HI[CW-1:0];
    else if (ty < LO) ry_d = LO[CW-1:0];
    else              ry_d = ty[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xc_q <= PW'(dx_i) * PW'(cos_i);
    p_ys_q <= PW'(dy_i) * PW'(sin_i);
    p_xs_q <= PW'(dx_i) * PW'(sin_i);
    p_yc_q <= PW'(dy_i) * PW'(cos_i);
    cx1_q  <= cx_i;
    cy1_q  <= cy_i;
    // floor by 2^30 is the upper part of the sum
    ox_q   <= sum_x[SW-1:Q_SHIFT];
    oy_q   <= sum_y[SW-1:Q_SHIFT];
    cx2_q  <= cx1_q;
    cy2_q  <= cy1_q;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    clip_q <= clx | cly;
  end

  assign valid_o = v3_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign clip_o  = clip_q;

endmodule

// ===== hdl/rotate_point_about_center.sv =====
// Top level: rotates a point about a center by a binary angle.
// Uses rpac_pkg, rpac_cordic_cell and rpac_combine.
//
//   channel   direction  handshake              word
//   --------  ---------  ---------------------  -----------------------------------
//   command   in         start_i & !busy_o      point, center, turn_angle
//   result    out        done_o (one cycle)     rotated_x, rotated_y, clipped
//
// One word is taken every cycle outside reset; each result passes through one entry
// stage, one register per CORDIC cell in the chain (at most ATAN_DEPTH cells),
// and three back-end stages (multiply, round, center add and clamp).
// busy_o is high only while reset is asserted; there is no clearing pass.
// The result side cannot stall, so nothing in the chain ever holds.
module rotate_point_about_center import rpac_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic [ANGLE_WIDTH-1:0]        turn_angle_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] rotated_x_o,
  output logic signed [COORD_WIDTH-1:0] rotated_y_o,
  output logic                          clipped_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int NS = (CORDIC_STAGES < ATAN_DEPTH) ? CORDIC_STAGES : ATAN_DEPTH;
  // the coordinate format is linear throughout; fraction bits change no bit
  localparam int FRAC_UNUSED = FRAC_BITS;

  logic                 accept;
  logic signed [ZW-1:0] z_raw, z_red;
  logic                 flip;
  logic signed [DW-1:0] dx_d, dy_d;

  logic                 v_c  [NS+1];
  logic signed [XW-1:0] x_c  [NS+1];
  logic signed [XW-1:0] y_c  [NS+1];
  logic signed [ZW-1:0] z_c  [NS+1];
  logic signed [DW-1:0] dx_c [NS+1];
  logic signed [DW-1:0] dy_c [NS+1];
  logic signed [CW-1:0] cx_c [NS+1];
  logic signed [CW-1:0] cy_c [NS+1];

  logic                 v0_q;
  logic signed [ZW-1:0] z0_q;
  logic signed [DW-1:0] dx0_q, dy0_q;
  logic signed [CW-1:0] cx0_q, cy0_q;

  assign busy_o = ~rst_ni;
  assign accept = start_i & ~busy_o;

  // angle to 2^-32 turn, folded into +-1/4 turn; a fold flips the offsets
  always_comb begin
    z_raw = $signed({turn_angle_i, {(ZW - ANGLE_WIDTH){1'b0}}});
    flip  = (z_raw > QUARTER_TURN) || (z_raw < -QUARTER_TURN);
    z_red = flip ? $signed({~z_raw[ZW-1], z_raw[ZW-2:0]}) : z_raw;
    if (flip) begin
      dx_d = DW'(center_x_i) - DW'(point_x_i);
      dy_d = DW'(center_y_i) - DW'(point_y_i);
    end else begin
      dx_d = DW'(point_x_i) - DW'(center_x_i);
      dy_d = DW'(point_y_i) - DW'(center_y_i);
    end
  end

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept && (FRAC_UNUSED >= 0);
    end
  end

  always_ff @(posedge clk_i) begin
    z0_q  <= z_red;
    dx0_q <= dx_d;
    dy0_q <= dy_d;
    cx0_q <= center_x_i;
    cy0_q <= center_y_i;
  end

  assign v_c[0]  = v0_q;
  assign x_c[0]  = GAIN_Q30;
  assign y_c[0]  = '0;
  assign z_c[0]  = z0_q;
  assign dx_c[0] = dx0_q;
  assign dy_c[0] = dy0_q;
  assign cx_c[0] = cx0_q;
  assign cy_c[0] = cy0_q;

  // CORDIC cell chain
  for (genvar g = 0; g < NS; g++) begin : g_cell
    rpac_cordic_cell #(
      .IDX (g),
      .DW  (DW),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_c[g]),
      .x_i     (x_c[g]),
      .y_i     (y_c[g]),
      .z_i     (z_c[g]),
      .dx_i    (dx_c[g]),
      .dy_i    (dy_c[g]),
      .cx_i    (cx_c[g]),
      .cy_i    (cy_c[g]),
      .valid_o (v_c[g+1]),
      .x_o     (x_c[g+1]),
      .y_o     (y_c[g+1]),
      .z_o     (z_c[g+1]),
      .dx_o    (dx_c[g+1]),
      .dy_o    (dy_c[g+1]),
      .cx_o    (cx_c[g+1]),
      .cy_o    (cy_c[g+1])
    );
  end

  // the final angle residue is not needed
  logic z_end_unused;
  assign z_end_unused = ^z_c[NS];

  rpac_combine #(
    .DW (DW),
    .CW (CW)
  ) u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_c[NS]),
    .cos_i   (x_c[NS]),
    .sin_i   (y_c[NS]),
    .dx_i    (dx_c[NS]),
    .dy_i    (dy_c[NS]),
    .cx_i    (cx_c[NS]),
    .cy_i    (cy_c[NS]),
    .valid_o (done_o),
    .rx_o    (rotated_x_o),
    .ry_o    (rotated_y_o),
    .clip_o  (clipped_o)
  );

endmodule

// ===== hdl/rpac_checker.sv =====
// Port-level checks for rotate_point_about_center, attached by bind.
// Depends on rpac_pkg and the top level's ports.
module rpac_checker import rpac_pkg::*; #(
  parameter int CW  = COORD_WIDTH_DEF,
  parameter int AW  = ANGLE_WIDTH_DEF,
  parameter int LAT = CORDIC_STAGES_DEF + 4
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic signed [CW-1:0] point_x_i,
  input logic signed [CW-1:0] point_y_i,
  input logic signed [CW-1:0] center_x_i,
  input logic signed [CW-1:0] center_y_i,
  input logic [AW-1:0]        turn_angle_i,
  input logic                 done_o,
  input logic signed [CW-1:0] rotated_x_o,
  input logic signed [CW-1:0] rotated_y_o,
  input logic                 clipped_o
);

  localparam logic signed [CW-1:0] HI = CW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [CW-1:0] LO = -HI - CW'(1);

  logic accept;
  logic on_center;
  logic angle_seen;

  assign accept     = start_i && !busy_o;
  assign on_center  = (point_x_i == center_x_i) && (point_y_i == center_y_i);
  assign angle_seen = ^turn_angle_i || !(^turn_angle_i);

  // every accepted word gives a later result strobe
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("command gave no result strobe at the expected latency");

  // every strobe traces back to an accepted word
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without a matching command");

  // a point on the center stays on the center, unclipped
  a_fixed_point : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(accept && on_center && angle_seen, LAT) |->
      rotated_x_o == $past(center_x_i, LAT) &&
      rotated_y_o == $past(center_y_i, LAT) && !clipped_o)
    else $error("point on the center moved");

  // a clipped result sits at an end of the coordinate range
  a_clip_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && clipped_o |->
      rotated_x_o == HI || rotated_x_o == LO ||
      rotated_y_o == HI || rotated_y_o == LO)
    else $error("clipped set on an unsaturated result");

  // no commands taken while reset is held, and no result right after it
  a_reset_quiet : assert property (@(posedge clk_i)
    !rst_ni |-> busy_o ##1 !done_o)
    else $error("activity during reset");

endmodule

bind rotate_point_about_center rpac_checker #(
  .CW  (COORD_WIDTH),
  .AW  (ANGLE_WIDTH),
  .LAT (((CORDIC_STAGES < 24) ? CORDIC_STAGES : 24) + 4)
) u_rpac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .point_x_i    (point_x_i),
  .point_y_i    (point_y_i),
  .center_x_i   (center_x_i),
  .center_y_i   (center_y_i),
  .turn_angle_i (turn_angle_i),
  .done_o       (done_o),
  .rotated_x_o  (rotated_x_o),
  .rotated_y_o  (rotated_y_o),
  .clipped_o    (clipped_o)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for rotate_point_about_center: drives point/center/angle words and
// checks each result word against a built-in CORDIC rotation predictor.
// Depends on hdl/rpac_pkg.sv and hdl/rotate_point_about_center.sv.
module tb;
  import rpac_pkg::*;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int AW      = ANGLE_WIDTH_DEF;
  localparam int STAGES  = CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 4;
  localparam int N_RANDOM    = 800;
  localparam int DRAIN_LIMIT = 4 * LATENCY + 100;
  localparam int PRINT_LIMIT = 50;

  // CORDIC constants: gain inverse in Q30, angles in 2^-32 turn
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint TURN_QTR    = 64'sd1073741824;
  localparam longint TURN_HALF   = 64'sd2147483648;
  localparam longint TURN_FULL   = 64'sd4294967296;
  localparam longint ATAN_TURN [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81
  };

  // Binary angles at the quadrant boundaries
  localparam logic [AW-1:0] ANG_ZERO = 16'h0000;
  localparam logic [AW-1:0] ANG_QTR  = 16'h4000;
  localparam logic [AW-1:0] ANG_HALF = 16'h8000;
  localparam logic [AW-1:0] ANG_3QTR = 16'hC000;
  localparam logic [AW-1:0] ANG_8TH  = 16'h2000;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [AW-1:0]        angle;
  } rot_cmd_t;

  typedef struct packed {
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic                 clip;
  } rot_res_t;

  // Clock, reset and DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic signed [CW-1:0] center_x = '0;
  logic signed [CW-1:0] center_y = '0;
  logic [AW-1:0]        turn_angle = '0;
  logic                 done;
  logic signed [CW-1:0] rotated_x;
  logic signed [CW-1:0] rotated_y;
  logic                 clipped;

  rot_cmd_t pending_cmds[$];
  rot_res_t expected_rotations[$];
  rot_cmd_t cur_cmd;
  int       n_total = 0;
  int       n_accepted = 0;
  int       n_errors = 0;
  int       burst_left = 0;
  int       gap_left = 0;

  rotate_point_about_center u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .center_x_i   (center_x),
    .center_y_i   (center_y),
    .turn_angle_i (turn_angle),
    .done_o       (done),
    .rotated_x_o  (rotated_x),
    .rotated_y_o  (rotated_y),
    .clipped_o    (clipped)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp to the signed coordinate range
  function automatic longint clamp_coord(longint v, inout logic clip);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Rotate the offset from the center with CORDIC sine/cosine, round, add back
  function automatic rot_res_t rotate_predict(rot_cmd_t cmd);
    longint   z;
    longint   cs;
    longint   sn;
    longint   xs;
    longint   ys;
    longint   dx;
    longint   dy;
    longint   rx;
    longint   ry;
    logic     flip;
    logic     clip;
    rot_res_t res;
    z    = longint'(cmd.angle) << (32 - AW);
    cs   = CORDIC_GAIN;
    sn   = 0;
    flip = 1'b0;
    clip = 1'b0;
    if (z >= TURN_HALF) z = z - TURN_FULL;
    // fold into +-1/4 turn; the half-turn offset negates sin and cos
    if (z > TURN_QTR) begin
      z    = z - TURN_HALF;
      flip = 1'b1;
    end else if (z < -TURN_QTR) begin
      z    = z + TURN_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = cs >>> i;
      ys = sn >>> i;
      if (z >= 0) begin
        cs = cs - ys;
        sn = sn + xs;
        z  = z - ATAN_TURN[i];
      end else begin
        cs = cs + ys;
        sn = sn - xs;
        z  = z + ATAN_TURN[i];
      end
    end
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    dx = longint'($signed(cmd.point_x)) - longint'($signed(cmd.center_x));
    dy = longint'($signed(cmd.point_y)) - longint'($signed(cmd.center_y));
    rx = (dx * cs - dy * sn + (64'sd1 <<< 29)) >>> 30;
    ry = (dx * sn + dy * cs + (64'sd1 <<< 29)) >>> 30;
    rx = clamp_coord(rx + longint'($signed(cmd.center_x)), clip);
    ry = clamp_coord(ry + longint'($signed(cmd.center_y)), clip);
    res.rx   = rx[CW-1:0];
    res.ry   = ry[CW-1:0];
    res.clip = clip;
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    if (n_errors < PRINT_LIMIT) $display("mismatch @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic queue_cmd(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                           logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                           logic [AW-1:0] ang);
    rot_cmd_t cmd;
    cmd.point_x  = px;
    cmd.point_y  = py;
    cmd.center_x = cx;
    cmd.center_y = cy;
    cmd.angle    = ang;
    pending_cmds.push_back(cmd);
  endtask

  // Coordinate draw: small, full range, or near either end of the range
  function automatic logic signed [CW-1:0] rand_coord(int kind);
    logic [31:0] r;
    r = $urandom;
    case (kind)
      0:       return CW'($signed(r[17:0]));
      1:       return r[CW-1:0];
      default: return r[0] ? C_MAX - CW'(r[15:1]) : C_MIN + CW'(r[15:1]);
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    logic [AW-1:0] ang;
    if ($urandom_range(0, 3) != 0) begin
      ang = AW'($urandom);
    end else begin
      // near a quadrant boundary
      ang = {2'($urandom_range(0, 3)), {(AW-2){1'b0}}};
      ang = ang + AW'($urandom_range(0, 6)) - AW'(3);
    end
    return ang;
  endfunction

  // Driver: bursts of words with random gaps; predicts on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // word held until taken
    end else begin
      if (start) begin
        expected_rotations.push_back(rotate_predict(cur_cmd));
        n_accepted++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        point_x    <= cur_cmd.point_x;
        point_y    <= cur_cmd.point_y;
        center_x   <= cur_cmd.center_x;
        center_y   <= cur_cmd.center_y;
        turn_angle <= cur_cmd.angle;
        start      <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    rot_res_t want;
    if (rst_ni && done) begin
      if (expected_rotations.size() == 0) begin
        flag_mismatch("result word with no prediction pending");
      end else begin
        want = expected_rotations.pop_front();
        if (rotated_x !== want.rx)
          flag_mismatch($sformatf("rotated_x got %0d want %0d", rotated_x, want.rx));
        if (rotated_y !== want.ry)
          flag_mismatch($sformatf("rotated_y got %0d want %0d", rotated_y, want.ry));
        if (clipped !== want.clip)
          flag_mismatch($sformatf("clipped got %0b want %0b", clipped, want.clip));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int kind;
    int idle;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    // angle folding around each quadrant boundary
    queue_cmd('0, '0, '0, '0, ANG_ZERO);
    queue_cmd(24'sd256, '0, '0, '0, ANG_QTR);
    queue_cmd(24'sd256, 24'sd77, '0, '0, ANG_QTR + AW'(1));
    queue_cmd(24'sd256, 24'sd77, 24'sd5, -24'sd9, ANG_HALF);
    queue_cmd(24'sd256, 24'sd77, 24'sd5, -24'sd9, ANG_HALF + AW'(1));
    queue_cmd(-24'sd300, 24'sd1000, 24'sd40, 24'sd40, ANG_3QTR);
    queue_cmd(-24'sd300, 24'sd1000, 24'sd40, 24'sd40, ANG_3QTR - AW'(1));
    queue_cmd(24'sd1000, -24'sd1000, '0, '0, 16'hFFFF);
    queue_cmd(24'sd1000, -24'sd1000, '0, '0, 16'h0001);
    queue_cmd(24'sd1000, 24'sd3, '0, '0, ANG_HALF - AW'(1));
    // saturation at both ends on both axes
    queue_cmd(C_MAX, C_MAX, C_MIN, C_MIN, ANG_ZERO);
    queue_cmd(C_MAX, C_MIN, C_MIN, C_MAX, ANG_HALF);
    queue_cmd(C_MIN, C_MAX, C_MAX, C_MIN, ANG_HALF);
    queue_cmd(C_MAX, '0, '0, '0, ANG_QTR);
    queue_cmd(C_MIN, C_MIN, '0, '0, ANG_QTR);
    queue_cmd(C_MAX, '0, C_MIN, '0, ANG_8TH);
    // point on the center, all-ones and alternating bit patterns
    queue_cmd(C_MAX, C_MAX, C_MAX, C_MAX, 16'h5A5A);
    queue_cmd(C_MIN, C_MIN, C_MIN, C_MIN, 16'h1234);
    queue_cmd(-24'sd1, -24'sd1, -24'sd1, -24'sd1, 16'hFFFF);
    queue_cmd(24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555, 16'h5555);
    queue_cmd(24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA, 16'hAAAA);
    queue_cmd(24'sd1, '0, '0, '0, ANG_8TH);

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // typical geometry: point a modest distance from its center
        px = rand_coord(1) >>> $urandom_range(1, 6);
        py = rand_coord(1) >>> $urandom_range(1, 6);
        queue_cmd(px + rand_coord(0), py + rand_coord(0), px, py, rand_angle());
      end else if (kind < 8) begin
        queue_cmd(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                  rand_angle());
      end else begin
        queue_cmd(rand_coord(2), rand_coord($urandom_range(0, 2)),
                  rand_coord($urandom_range(0, 2)), rand_coord(2), rand_angle());
      end
    end
    n_total = pending_cmds.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total) @(posedge clk_i);
    idle = 0;
    while (expected_rotations.size() > 0 && idle < DRAIN_LIMIT) begin
      @(posedge clk_i);
      idle++;
    end
    if (expected_rotations.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived",
                              expected_rotations.size()));
    repeat (LATENCY + 8) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
